// ===== design/soft_interrupt_priority_dispatcher_defines.svh =====
`ifndef SOFT_INTERRUPT_PRIORITY_DISPATCHER_DEFINES_SVH
`define SOFT_INTERRUPT_PRIORITY_DISPATCHER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SIPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SIPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sipd_pkg.sv =====
package sipd_pkg;

    localparam int CMD_W   = 2;
    localparam int ID_W    = 7;
    localparam int PRIO_W  = 5;
    localparam int STAT_W  = 2;
    localparam int LEVEL_W = 6;

    localparam int NUM_IDS_DEF     = 128;
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int NEST_MAX        = 32;
    localparam int NEST_AW         = $clog2(NEST_MAX);

    localparam logic [LEVEL_W-1:0] IDLE_LEVEL = LEVEL_W'(32);

    localparam logic [CMD_W-1:0] CMD_CREATE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACTIVATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ID_W-1:0]   swi_id;
        logic [PRIO_W-1:0] prio;
    } in_beat_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               start_valid;
        logic [ID_W-1:0]    start_id;
        logic [PRIO_W-1:0]  start_prio;
        logic [LEVEL_W-1:0] running_level;
    } out_beat_t;

    typedef struct packed {
        logic              registered;
        logic [PRIO_W-1:0] prio;
    } tbl_entry_t;

    typedef struct packed {
        logic [ID_W-1:0]   swi_id;
        logic [PRIO_W-1:0] prio;
    } q_entry_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SWEEP,
        OP_CREATE,
        OP_REJECT,
        OP_FULL,
        OP_PREEMPT,
        OP_ENQ_EMPTY,
        OP_SCAN_START,
        OP_SHIFT,
        OP_PLACE,
        OP_FINISH,
        OP_CLEAR,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             in_range;
        logic             registered;
        logic             preempt_ok;
        logic             nest_full;
        logic             nest_zero;
        logic             q_full;
        logic             q_empty;
        logic             scan_gt;
        logic             scan_at_head;
        logic             level_idle;
        logic             sweep_last;
        logic             out_free;
    } dp_stat_t;

endpackage

// ===== design/sipd_ram.sv =====
module sipd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/sipd_ctrl.sv =====
module sipd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sipd_pkg::dp_stat_t stat,
    output sipd_pkg::ctrl_t    ctrl
);

    import sipd_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_FETCH,
        S_DECIDE,
        S_SCAN,
        S_HEAD,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    dp_op_t op;

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_INIT: begin
                op = OP_SWEEP;
                if (stat.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op         = OP_LOAD;
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                unique case (stat.cmd)
                    CMD_CREATE, CMD_ACTIVATE: begin
                        state_next = S_DECIDE;
                    end
                    CMD_FINISH: begin
                        op         = stat.nest_zero ? OP_REJECT : OP_FINISH;
                        state_next = S_DONE;
                    end
                    CMD_CLEAR: begin
                        if (stat.level_idle) begin
                            op         = OP_CLEAR;
                            state_next = S_CLEAR;
                        end else begin
                            op         = OP_REJECT;
                            state_next = S_DONE;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DECIDE: begin
                state_next = S_DONE;
                if (!stat.in_range) begin
                    op = OP_REJECT;
                end else if (stat.cmd == CMD_CREATE) begin
                    op = stat.registered ? OP_REJECT : OP_CREATE;
                end else begin
                    priority if (!stat.registered) begin
                        op = OP_REJECT;
                    end else if (stat.preempt_ok) begin
                        op = stat.nest_full ? OP_REJECT : OP_PREEMPT;
                    end else if (stat.q_full) begin
                        op = OP_FULL;
                    end else if (stat.q_empty) begin
                        op = OP_ENQ_EMPTY;
                    end else begin
                        op         = OP_SCAN_START;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (stat.scan_gt) begin
                    op = OP_SHIFT;
                    if (stat.scan_at_head) begin
                        state_next = S_HEAD;
                    end
                end else begin
                    op         = OP_PLACE;
                    state_next = S_DONE;
                end
            end
            S_HEAD: begin
                op         = OP_PLACE;
                state_next = S_DONE;
            end
            S_CLEAR: begin
                op = OP_SWEEP;
                if (stat.sweep_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign ctrl.op = op;

endmodule

// ===== design/sipd_dp.sv =====
`include "soft_interrupt_priority_dispatcher_defines.svh"

module sipd_dp #(
    parameter int NUM_IDS     = sipd_pkg::NUM_IDS_DEF,
    parameter int QUEUE_DEPTH = sipd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sipd_pkg::in_beat_t  s_data,
    input  sipd_pkg::ctrl_t     ctrl,
    output sipd_pkg::dp_stat_t  stat,
    output logic                m_valid,
    input  logic                m_ready,
    output sipd_pkg::out_beat_t m_data
);

    import sipd_pkg::*;

    localparam int ID_AW = $clog2(NUM_IDS);
    localparam int Q_AW  = $clog2(QUEUE_DEPTH);
    localparam int Q_CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = ID_AW + ID_W;

    localparam logic [Q_AW-1:0]  Q_LAST  = Q_AW'(QUEUE_DEPTH - 1);
    localparam logic [Q_AW:0]    Q_SPAN  = (Q_AW + 1)'(QUEUE_DEPTH);
    localparam logic [Q_CW-1:0]  Q_FULL  = Q_CW'(QUEUE_DEPTH);
    localparam logic [ID_AW-1:0] ID_LAST = ID_AW'(NUM_IDS - 1);

    function automatic logic [Q_AW-1:0] q_inc(input logic [Q_AW-1:0] p);
        return (p == Q_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [Q_AW-1:0] q_dec(input logic [Q_AW-1:0] p);
        return (p == '0) ? Q_LAST : p - 1'b1;
    endfunction

    in_beat_t            in_reg;
    logic [LEVEL_W-1:0]  cur_reg, cur_next;
    logic [LEVEL_W-1:0]  nest_reg, nest_next;
    logic [Q_CW-1:0]     cnt_reg, cnt_next;
    logic [Q_AW-1:0]     head_reg, head_next;
    logic [Q_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [Q_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ID_AW-1:0]    sweep_reg, sweep_next;
    out_beat_t           res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    out_beat_t           m_data_reg;

    logic [EXT_W-1:0]    id_ext;
    logic [ID_AW-1:0]    idx;
    logic                in_range;
    logic [PRIO_W-1:0]   ip;
    logic [Q_AW:0]       q_sum;
    logic [Q_AW-1:0]     q_wr_start;
    logic                take_head;
    logic                out_free;

    tbl_entry_t          tbl_rdata, tbl_wdata;
    logic                tbl_we;
    logic [ID_AW-1:0]    tbl_waddr;
    q_entry_t            q_rdata, q_wdata;
    logic                q_we;
    logic [Q_AW-1:0]     q_waddr;
    logic [LEVEL_W-1:0]  stk_rdata;
    logic                stk_we;
    logic [NEST_AW-1:0]  stk_raddr;

    assign id_ext   = EXT_W'(in_reg.swi_id);
    assign idx      = id_ext[ID_AW-1:0];
    assign in_range = (32'(in_reg.swi_id) < NUM_IDS);
    assign ip       = tbl_rdata.prio;

    assign q_sum      = {1'b0, head_reg} + (Q_AW + 1)'(cnt_reg);
    assign q_wr_start = (q_sum >= Q_SPAN) ? Q_AW'(q_sum - Q_SPAN) : Q_AW'(q_sum);

    assign take_head = (cnt_reg != '0) && ({1'b0, q_rdata.prio} < stk_rdata);
    assign out_free  = !m_valid_reg || m_ready;
    assign stk_raddr = NEST_AW'(nest_reg - 1'b1);

    assign tbl_we    = (ctrl.op == OP_SWEEP) || (ctrl.op == OP_CREATE);
    assign tbl_waddr = (ctrl.op == OP_SWEEP) ? sweep_reg : idx;
    assign tbl_wdata = (ctrl.op == OP_SWEEP) ? tbl_entry_t'('0)
                                             : tbl_entry_t'{registered: 1'b1, prio: in_reg.prio};

    assign q_we    = (ctrl.op == OP_ENQ_EMPTY) || (ctrl.op == OP_SHIFT) || (ctrl.op == OP_PLACE);
    assign q_waddr = (ctrl.op == OP_ENQ_EMPTY) ? head_reg : wr_ptr_reg;
    assign q_wdata = (ctrl.op == OP_SHIFT) ? q_rdata
                                           : q_entry_t'{swi_id: in_reg.swi_id, prio: ip};

    assign stk_we = (ctrl.op == OP_PREEMPT);

    always_comb begin
        cur_next     = cur_reg;
        nest_next    = nest_reg;
        cnt_next     = cnt_reg;
        head_next    = head_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        sweep_next   = sweep_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (ctrl.op)
            OP_NONE: begin
            end
            OP_LOAD: begin
                rd_ptr_next = head_reg;
            end
            OP_SWEEP: begin
                sweep_next = (sweep_reg == ID_LAST) ? '0 : sweep_reg + 1'b1;
            end
            OP_CREATE, OP_ENQ_EMPTY, OP_PLACE, OP_CLEAR: begin
                if (ctrl.op == OP_ENQ_EMPTY || ctrl.op == OP_PLACE) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (ctrl.op == OP_CLEAR) begin
                    cnt_next   = '0;
                    nest_next  = '0;
                    head_next  = '0;
                    sweep_next = '0;
                end
                res_next = '{status: ST_OK, start_valid: 1'b0, start_id: '0,
                             start_prio: '0, running_level: cur_reg};
            end
            OP_REJECT, OP_FULL: begin
                res_next = '{status: (ctrl.op == OP_FULL) ? ST_FULL : ST_REJECT,
                             start_valid: 1'b0, start_id: '0, start_prio: '0,
                             running_level: cur_reg};
            end
            OP_PREEMPT: begin
                nest_next = nest_reg + 1'b1;
                cur_next  = LEVEL_W'(ip);
                res_next  = '{status: ST_OK, start_valid: 1'b1, start_id: in_reg.swi_id,
                              start_prio: ip, running_level: LEVEL_W'(ip)};
            end
            OP_SCAN_START: begin
                wr_ptr_next = q_wr_start;
                rd_ptr_next = q_dec(q_wr_start);
            end
            OP_SHIFT: begin
                wr_ptr_next = rd_ptr_reg;
                rd_ptr_next = q_dec(rd_ptr_reg);
            end
            OP_FINISH: begin
                if (take_head) begin
                    head_next = q_inc(head_reg);
                    cnt_next  = cnt_reg - 1'b1;
                    cur_next  = LEVEL_W'(q_rdata.prio);
                    res_next  = '{status: ST_OK, start_valid: 1'b1, start_id: q_rdata.swi_id,
                                  start_prio: q_rdata.prio,
                                  running_level: LEVEL_W'(q_rdata.prio)};
                end else begin
                    nest_next = nest_reg - 1'b1;
                    cur_next  = stk_rdata;
                    res_next  = '{status: ST_OK, start_valid: 1'b0, start_id: '0,
                                  start_prio: '0, running_level: stk_rdata};
                end
            end
            OP_EMIT: begin
                m_valid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg     <= IDLE_LEVEL;
            nest_reg    <= '0;
            cnt_reg     <= '0;
            head_reg    <= '0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_reg     <= cur_next;
            nest_reg    <= nest_next;
            cnt_reg     <= cnt_next;
            head_reg    <= head_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        res_reg    <= res_next;
        if (ctrl.op == OP_LOAD) begin
            in_reg <= s_data;
        end
        if (ctrl.op == OP_EMIT) begin
            m_data_reg <= res_reg;
        end
    end

    sipd_ram #(
        .WIDTH($bits(tbl_entry_t)),
        .DEPTH(NUM_IDS)
    ) u_tbl_ram (
        .aclk (aclk),
        .we   (tbl_we),
        .waddr(tbl_waddr),
        .wdata(tbl_wdata),
        .raddr(idx),
        .rdata(tbl_rdata)
    );

    sipd_ram #(
        .WIDTH($bits(q_entry_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_q_ram (
        .aclk (aclk),
        .we   (q_we),
        .waddr(q_waddr),
        .wdata(q_wdata),
        .raddr(rd_ptr_next),
        .rdata(q_rdata)
    );

    sipd_ram #(
        .WIDTH(LEVEL_W),
        .DEPTH(NEST_MAX)
    ) u_stk_ram (
        .aclk (aclk),
        .we   (stk_we),
        .waddr(nest_reg[NEST_AW-1:0]),
        .wdata(cur_reg),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    assign stat.cmd          = in_reg.command;
    assign stat.in_range     = in_range;
    assign stat.registered   = tbl_rdata.registered;
    assign stat.preempt_ok   = ({1'b0, ip} < cur_reg);
    assign stat.nest_full    = (nest_reg >= LEVEL_W'(NEST_MAX));
    assign stat.nest_zero    = (nest_reg == '0);
    assign stat.q_full       = (cnt_reg == Q_FULL);
    assign stat.q_empty      = (cnt_reg == '0);
    assign stat.scan_gt      = (q_rdata.prio > ip);
    assign stat.scan_at_head = (rd_ptr_reg == head_reg);
    assign stat.level_idle   = (cur_reg == IDLE_LEVEL);
    assign stat.sweep_last   = (sweep_reg == ID_LAST);
    assign stat.out_free     = out_free;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SIPD_ASSERT_NOW(a_idle_iff_no_nest, aclk, aresetn, 1'b1,
        (nest_reg == '0) == (cur_reg == IDLE_LEVEL), "running level and nesting disagree")
    `SIPD_ASSERT_NOW(a_nest_bound, aclk, aresetn, 1'b1,
        nest_reg <= LEVEL_W'(NEST_MAX), "nesting beyond saved level capacity")
    `SIPD_ASSERT_NOW(a_queue_bound, aclk, aresetn, 1'b1,
        cnt_reg <= Q_FULL, "pending count beyond queue depth")
    `SIPD_ASSERT_NOW(a_start_sets_level, aclk, aresetn, m_valid_reg && m_data_reg.start_valid,
        LEVEL_W'(m_data_reg.start_prio) == m_data_reg.running_level,
        "dispatched handler does not set running level")
    `SIPD_ASSERT_NEXT(a_emit_fills_slot, aclk, aresetn, ctrl.op == OP_EMIT,
        m_valid_reg, "result beat lost on emit")

endmodule

// ===== design/soft_interrupt_priority_dispatcher.sv =====
// handling: finish and rejected clear are answered from the fetch step; create and activate
// go through a decide step, and activate into a nonempty queue adds an insert walk that
// shifts entries; clear sweeps the id table; throughput: one item at a time, s_ready rises
// with the result beat, which waits for the output slot to be free
// reset: aresetn synchronous active low; the id table RAM is then swept, with s_ready low,
// before the first beat is taken
module soft_interrupt_priority_dispatcher #(
    parameter int NUM_IDS     = sipd_pkg::NUM_IDS_DEF,
    parameter int QUEUE_DEPTH = sipd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sipd_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sipd_pkg::out_beat_t m_data
);

    import sipd_pkg::*;

    ctrl_t    ctrl;
    dp_stat_t stat;

    sipd_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .ctrl   (ctrl)
    );

    sipd_dp #(
        .NUM_IDS    (NUM_IDS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .ctrl   (ctrl),
        .stat   (stat),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sipd_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_BEATS = 500;

    typedef struct {
        in_beat_t  beat;
        bit        typed;
        out_beat_t want;
    } stim_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    soft_interrupt_priority_dispatcher #(
        .NUM_IDS    (NUM_IDS_DEF),
        .QUEUE_DEPTH(QUEUE_DEPTH_DEF)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // dispatcher state as software sees it
    bit                 tbl_reg[NUM_IDS_DEF];
    logic [PRIO_W-1:0]  tbl_prio[NUM_IDS_DEF];
    logic [ID_W-1:0]    pend_id[QUEUE_DEPTH_DEF];
    logic [PRIO_W-1:0]  pend_prio[QUEUE_DEPTH_DEF];
    int                 pend_cnt = 0;
    logic [LEVEL_W-1:0] lvl_stack[NEST_MAX];
    int                 nest = 0;
    logic [LEVEL_W-1:0] run_level = IDLE_LEVEL;

    out_beat_t expected_results[$];
    stim_row_t directed_rows[$];
    int        fails = 0;
    int        cycles = 0;
    int        beats_sent = 0;
    bit        quiet_tx = 1'b0;
    bit        quiet_rx = 1'b0;

    function automatic in_beat_t mk_beat(logic [CMD_W-1:0] c, int id, int p);
        in_beat_t b;
        b.command = c;
        b.swi_id  = ID_W'(id);
        b.prio    = PRIO_W'(p);
        return b;
    endfunction

    function automatic void add_row(logic [CMD_W-1:0] c, int id, int p, bit typed,
                                    logic [STAT_W-1:0] st, bit sv, int sid, int sp, int lvl);
        stim_row_t r;
        r.beat                = mk_beat(c, id, p);
        r.typed               = typed;
        r.want.status         = st;
        r.want.start_valid    = sv;
        r.want.start_id       = ID_W'(sid);
        r.want.start_prio     = PRIO_W'(sp);
        r.want.running_level  = LEVEL_W'(lvl);
        directed_rows.push_back(r);
    endfunction

    function automatic out_beat_t dispatch_step(in_beat_t b);
        out_beat_t         r;
        int                pos;
        int                k;
        logic [ID_W-1:0]   hid;
        logic [PRIO_W-1:0] hp;
        r = '0;
        r.status = ST_OK;
        case (b.command)
            CMD_CREATE: begin
                if (int'(b.swi_id) >= NUM_IDS_DEF || tbl_reg[b.swi_id]) begin
                    r.status = ST_REJECT;
                end else begin
                    tbl_reg[b.swi_id]  = 1'b1;
                    tbl_prio[b.swi_id] = b.prio;
                end
            end
            CMD_ACTIVATE: begin
                if (int'(b.swi_id) >= NUM_IDS_DEF || !tbl_reg[b.swi_id]) begin
                    r.status = ST_REJECT;
                end else if ({1'b0, tbl_prio[b.swi_id]} < run_level) begin
                    if (nest >= NEST_MAX) begin
                        r.status = ST_REJECT;
                    end else begin
                        lvl_stack[nest] = run_level;
                        nest++;
                        run_level     = LEVEL_W'(tbl_prio[b.swi_id]);
                        r.start_valid = 1'b1;
                        r.start_id    = b.swi_id;
                        r.start_prio  = tbl_prio[b.swi_id];
                    end
                end else if (pend_cnt >= QUEUE_DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < pend_cnt && pend_prio[pos] <= tbl_prio[b.swi_id]) pos++;
                    for (k = pend_cnt; k > pos; k--) begin
                        pend_id[k]   = pend_id[k-1];
                        pend_prio[k] = pend_prio[k-1];
                    end
                    pend_id[pos]   = b.swi_id;
                    pend_prio[pos] = tbl_prio[b.swi_id];
                    pend_cnt++;
                end
            end
            CMD_FINISH: begin
                if (nest == 0) begin
                    r.status = ST_REJECT;
                end else begin
                    nest--;
                    run_level = lvl_stack[nest];
                    if (pend_cnt > 0 && {1'b0, pend_prio[0]} < run_level) begin
                        hid = pend_id[0];
                        hp  = pend_prio[0];
                        for (k = 1; k < pend_cnt; k++) begin
                            pend_id[k-1]   = pend_id[k];
                            pend_prio[k-1] = pend_prio[k];
                        end
                        pend_cnt--;
                        if (nest < NEST_MAX) begin
                            lvl_stack[nest] = run_level;
                            nest++;
                            run_level     = LEVEL_W'(hp);
                            r.start_valid = 1'b1;
                            r.start_id    = hid;
                            r.start_prio  = hp;
                        end
                    end
                end
            end
            default: begin
                if (run_level != IDLE_LEVEL) begin
                    r.status = ST_REJECT;
                end else begin
                    for (k = 0; k < NUM_IDS_DEF; k++) tbl_reg[k] = 1'b0;
                    pend_cnt = 0;
                    nest     = 0;
                end
            end
        endcase
        r.running_level = run_level;
        return r;
    endfunction

    task automatic send_cmd(input in_beat_t b, input bit typed, input out_beat_t want);
        int        gap;
        out_beat_t predicted;
        gap = quiet_tx ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 29) == 0) quiet_tx = !quiet_tx;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= b;
        s_valid <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = dispatch_step(b);
        expected_results.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    initial begin : stimulus
        int sel;
        int id;
        int p;
        int k;
        int fl_n;
        int fl_ids[12];
        int i;
        add_row(CMD_FINISH,   3,   7, 1, ST_REJECT, 0, 0, 0, 32);
        add_row(CMD_ACTIVATE, 127, 31, 1, ST_REJECT, 0, 0, 0, 32);
        add_row(CMD_CLEAR,    0,   0, 1, ST_OK,     0, 0, 0, 32);
        add_row(CMD_CREATE,   0,   31, 1, ST_OK,    0, 0, 0, 32);
        add_row(CMD_CREATE,   0,   0, 1, ST_REJECT, 0, 0, 0, 32);
        add_row(CMD_CREATE,   127, 0, 1, ST_OK,     0, 0, 0, 32);
        add_row(CMD_CREATE,   85,  21, 0, ST_OK,    0, 0, 0, 0);
        add_row(CMD_CREATE,   42,  10, 0, ST_OK,    0, 0, 0, 0);
        add_row(CMD_ACTIVATE, 0,   0, 1, ST_OK,     1, 0, 31, 31);
        add_row(CMD_ACTIVATE, 42,  0, 0, ST_OK,     0, 0, 0, 0);
        add_row(CMD_CLEAR,    127, 31, 1, ST_REJECT, 0, 0, 0, 10);
        add_row(CMD_ACTIVATE, 85,  0, 0, ST_OK,     0, 0, 0, 0);
        add_row(CMD_ACTIVATE, 0,   0, 0, ST_OK,     0, 0, 0, 0);
        add_row(CMD_ACTIVATE, 42,  0, 0, ST_OK,     0, 0, 0, 0);
        add_row(CMD_ACTIVATE, 127, 0, 0, ST_OK,     0, 0, 0, 0);
        add_row(CMD_ACTIVATE, 127, 0, 0, ST_OK,     0, 0, 0, 0);
        for (i = 0; i < 7; i++) add_row(CMD_FINISH, 0, 0, 0, ST_OK, 0, 0, 0, 0);
        add_row(CMD_FINISH,   127, 31, 1, ST_REJECT, 0, 0, 0, 32);
        add_row(CMD_CLEAR,    0,   0, 1, ST_OK,     0, 0, 0, 32);
        add_row(CMD_ACTIVATE, 0,   0, 1, ST_REJECT, 0, 0, 0, 32);

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) send_cmd(directed_rows[r].beat, directed_rows[r].typed,
                                            directed_rows[r].want);

        while (beats_sent < directed_rows.size() + RANDOM_BEATS) begin
            if ($urandom_range(0, 39) == 0) begin
                // unwind to idle, clear, then overrun the pending queue under a level-0 handler
                while (nest != 0) send_cmd(mk_beat(CMD_FINISH, $urandom_range(0, 127),
                                                   $urandom_range(0, 31)), 0, '0);
                send_cmd(mk_beat(CMD_CLEAR, $urandom_range(0, 127), $urandom_range(0, 31)),
                         0, '0);
                fl_n = $urandom_range(4, 12);
                for (i = 0; i < fl_n; i++) begin
                    fl_ids[i] = $urandom_range(0, 127);
                    send_cmd(mk_beat(CMD_CREATE, fl_ids[i], (i == 0) ? 0 : $urandom_range(0, 31)),
                             0, '0);
                end
                send_cmd(mk_beat(CMD_ACTIVATE, fl_ids[0], $urandom_range(0, 31)), 0, '0);
                repeat ($urandom_range(QUEUE_DEPTH_DEF + 1, QUEUE_DEPTH_DEF + 8))
                    send_cmd(mk_beat(CMD_ACTIVATE, fl_ids[$urandom_range(0, fl_n - 1)],
                                     $urandom_range(0, 31)), 0, '0);
            end else begin
                sel = $urandom_range(0, 99);
                id  = $urandom_range(0, 127);
                p   = $urandom_range(0, 31);
                if (sel < 25) begin
                    send_cmd(mk_beat(CMD_CREATE, id, p), 0, '0);
                end else if (sel < 65) begin
                    if ($urandom_range(0, 4) != 0) begin
                        for (k = 0; k < NUM_IDS_DEF; k++) begin
                            if (tbl_reg[(id + k) % NUM_IDS_DEF]) begin
                                id = (id + k) % NUM_IDS_DEF;
                                break;
                            end
                        end
                    end
                    send_cmd(mk_beat(CMD_ACTIVATE, id, p), 0, '0);
                end else if (sel < 95) begin
                    send_cmd(mk_beat(CMD_FINISH, id, p), 0, '0);
                end else begin
                    send_cmd(mk_beat(CMD_CLEAR, id, p), 0, '0);
                end
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (NUM_IDS_DEF + 16) @(posedge aclk);
        if (fails == 0) begin
            $display("soft_interrupt_priority_dispatcher: match");
        end else begin
            $display("soft_interrupt_priority_dispatcher: mismatch");
        end
        $finish;
    end

    initial begin : result_sink
        int stall;
        forever begin
            stall = quiet_rx ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 29) == 0) quiet_rx = !quiet_rx;
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && aresetn === 1'b1));
        end
    end

    always @(posedge aclk) begin : result_check
        out_beat_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected: %h", m_data);
                fails++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status expected %0d got %0d", want.status, m_data.status);
                    fails++;
                end
                if (m_data.start_valid !== want.start_valid) begin
                    $error("start_valid expected %0d got %0d", want.start_valid,
                           m_data.start_valid);
                    fails++;
                end
                if (m_data.start_id !== want.start_id) begin
                    $error("start_id expected %0d got %0d", want.start_id, m_data.start_id);
                    fails++;
                end
                if (m_data.start_prio !== want.start_prio) begin
                    $error("start_prio expected %0d got %0d", want.start_prio,
                           m_data.start_prio);
                    fails++;
                end
                if (m_data.running_level !== want.running_level) begin
                    $error("running_level expected %0d got %0d", want.running_level,
                           m_data.running_level);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("soft_interrupt_priority_dispatcher: mismatch");
            $finish;
        end
    end

endmodule
